// ===== rtl/core/owrs_pkg.sv =====
// shared types and constants of the 1-wire rom search controller
package owrs_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START_FIRST = 2'd0,
    KIND_START_NEXT  = 2'd1,
    KIND_PRESENCE    = 2'd2,
    KIND_BIT_PAIR    = 2'd3
  } owrs_kind_e;

  // bus actions on the result channel
  typedef enum logic [2:0] {
    ACT_BUS_RESET  = 3'd0,
    ACT_WRITE_BYTE = 3'd1,
    ACT_READ_PAIR  = 3'd2,
    ACT_WRITE_BIT  = 3'd3,
    ACT_DONE       = 3'd4
  } owrs_action_e;

  localparam logic [7:0] SEARCH_CMD   = 8'hF0;
  localparam logic [6:0] END_POSITION = 7'd65;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  // one input item
  typedef struct packed {
    owrs_kind_e kind;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } owrs_item_t;

  // results caused by one item: one or two actions
  typedef struct packed {
    owrs_action_e act0;
    owrs_action_e act1;
    logic         two;
    logic         dir;
    logic         found;
    logic [63:0]  rom;
  } owrs_pkt_t;

endpackage

// ===== rtl/core/owrs_in_reg.sv =====
// input register stage of the rom search controller
module owrs_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  owrs_pkg::owrs_item_t item_i,
  output logic                valid_o,
  output owrs_pkg::owrs_item_t item_o,
  input  logic                take_i
);
  import owrs_pkg::*;

  logic       valid_q;
  owrs_item_t item_q;
  logic       accept;

  // room when empty or when the held item moves on this cycle
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/owrs_search.sv =====
// search state and per-item decision logic
module owrs_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  owrs_pkg::owrs_item_t item_i,
  output logic                 has_res_o,
  output owrs_pkg::owrs_pkt_t  pkt_o
);
  import owrs_pkg::*;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESENCE = 2'd1;
  localparam logic [1:0] PH_PAIR     = 2'd2;

  logic [63:0] rom_q, rom_d;
  logic [6:0]  ld_q, ld_d;
  logic [3:0]  lfd_q, lfd_d;
  logic        ldf_q, ldf_d;
  logic [6:0]  pos_q, pos_d;
  logic [6:0]  lzp_q, lzp_d;
  logic [1:0]  phase_q, phase_d;

  logic [6:0]  pos_nx;
  logic [5:0]  idx;
  logic        dir;
  logic        ldf_eff;
  owrs_pkt_t   pkt;
  logic        has_res;

  assign pos_nx = pos_q + 7'd1;
  assign idx    = pos_q[5:0] - 6'd1;

  // decision for the current item
  always_comb begin
    rom_d   = rom_q;
    ld_d    = ld_q;
    lfd_d   = lfd_q;
    ldf_d   = ldf_q;
    pos_d   = pos_q;
    lzp_d   = lzp_q;
    phase_d = phase_q;
    has_res = 1'b0;
    dir     = 1'b0;
    ldf_eff = ldf_q;
    pkt.act0  = ACT_DONE;
    pkt.act1  = ACT_DONE;
    pkt.two   = 1'b0;
    pkt.found = 1'b0;
    unique case (item_i.kind)
      KIND_START_FIRST, KIND_START_NEXT: begin
        has_res = 1'b1;
        if (item_i.kind == KIND_START_FIRST) begin
          ld_d    = '0;
          lfd_d   = '0;
          ldf_d   = 1'b0;
          ldf_eff = 1'b0;
        end
        if (ldf_eff) begin
          ld_d    = '0;
          lfd_d   = '0;
          ldf_d   = 1'b0;
          phase_d = PH_IDLE;
        end else begin
          pos_d    = 7'd1;
          lzp_d    = '0;
          phase_d  = PH_PRESENCE;
          pkt.act0 = ACT_BUS_RESET;
        end
      end
      KIND_PRESENCE: begin
        if (phase_q == PH_PRESENCE) begin
          has_res = 1'b1;
          if (!item_i.presence) begin
            ld_d    = '0;
            lfd_d   = '0;
            ldf_d   = 1'b0;
            phase_d = PH_IDLE;
          end else begin
            phase_d  = PH_PAIR;
            pkt.act0 = ACT_WRITE_BYTE;
            pkt.act1 = ACT_READ_PAIR;
            pkt.two  = 1'b1;
          end
        end
      end
      KIND_BIT_PAIR: begin
        if (phase_q == PH_PAIR) begin
          has_res = 1'b1;
          if (item_i.id_bit && item_i.complement_bit) begin
            ld_d    = '0;
            lfd_d   = '0;
            ldf_d   = 1'b0;
            phase_d = PH_IDLE;
          end else begin
            // direction: a clean bit, else follow the last discrepancy
            if (item_i.id_bit != item_i.complement_bit) begin
              dir = item_i.id_bit;
            end else begin
              if (pos_q < ld_q) begin
                dir = rom_q[idx];
              end else begin
                dir = (pos_q == ld_q);
              end
              if (!dir) begin
                lzp_d = pos_q;
                if (pos_q < FAMILY_LIMIT) begin
                  lfd_d = pos_q[3:0];
                end
              end
            end
            rom_d[idx] = dir;
            pos_d      = pos_nx;
            pkt.act0   = ACT_WRITE_BIT;
            pkt.two    = 1'b1;
            if (pos_nx < END_POSITION) begin
              pkt.act1 = ACT_READ_PAIR;
            end else begin
              // whole id read: finish the search
              ld_d  = lzp_d;
              ldf_d = (lzp_d == 7'd0);
              if (rom_d[7:0] == 8'd0) begin
                ld_d    = '0;
                lfd_d   = '0;
                ldf_d   = 1'b0;
                phase_d = PH_IDLE;
              end else begin
                phase_d   = PH_IDLE;
                pkt.found = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
    pkt.dir = dir;
    pkt.rom = rom_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q   <= '0;
      ld_q    <= '0;
      lfd_q   <= '0;
      ldf_q   <= 1'b0;
      pos_q   <= 7'd1;
      lzp_q   <= '0;
      phase_q <= PH_IDLE;
    end else if (fire_i) begin
      rom_q   <= rom_d;
      ld_q    <= ld_d;
      lfd_q   <= lfd_d;
      ldf_q   <= ldf_d;
      pos_q   <= pos_d;
      lzp_q   <= lzp_d;
      phase_q <= phase_d;
    end
  end

  assign has_res_o = has_res;
  assign pkt_o     = pkt;

endmodule

// ===== rtl/core/owrs_out_buf.sv =====
// result register holding the actions of one item
module owrs_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  owrs_pkg::owrs_pkt_t pkt_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          action_o,
  output logic [7:0]          byte_out_o,
  output logic                bit_out_o,
  output logic                found_o,
  output logic [63:0]         rom_id_o,
  output logic                last_o
);
  import owrs_pkg::*;

  logic         valid_q;
  logic         idx_q;
  owrs_pkt_t    pkt_q;
  logic         xfer;
  logic         is_last;
  owrs_action_e act;

  assign act     = idx_q ? pkt_q.act1 : pkt_q.act0;
  assign is_last = idx_q || !pkt_q.two;
  assign xfer    = valid_q && !out_stall_i;
  assign free_o  = !valid_q || (xfer && is_last);

  // packet valid and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (xfer) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= 1'b1;
      end
    end
  end

  // packet payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pkt_q <= pkt_i;
    end
  end

  // field formatting per action
  assign out_valid_o = valid_q;
  assign action_o    = act;
  assign byte_out_o  = (act == ACT_WRITE_BYTE) ? SEARCH_CMD : 8'd0;
  assign bit_out_o   = (act == ACT_WRITE_BIT) ? pkt_q.dir : 1'b0;
  assign found_o     = (act == ACT_DONE) ? pkt_q.found : 1'b0;
  assign rom_id_o    = (act == ACT_DONE) ? pkt_q.rom : 64'd0;
  assign last_o      = is_last;

endmodule

// ===== rtl/core/onewire_rom_search.sv =====
// Top level of the 1-wire rom search controller. Each accepted item passes an input
// register, the decision logic against the search state, and lands in a result
// register that holds the one or two bus actions the item causes. A new item is taken
// every cycle as long as each item gives one result and results drain: start requests
// give one result, presence and bit pair answers give two (or one on failure), and an
// item is decided only when the last result of the one before transfers or has gone,
// so the result channel, one transfer per cycle when not stalled, sets the sustained
// rate. Answers that arrive in the wrong phase produce no result.
module onewire_rom_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic        presence_i,
  input  logic        id_bit_i,
  input  logic        complement_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  byte_out_o,
  output logic        bit_out_o,
  output logic        found_o,
  output logic [63:0] rom_id_o,
  output logic        last_o
);
  import owrs_pkg::*;

  owrs_item_t item_in;
  owrs_item_t item_q;
  logic       item_valid;
  logic       buf_free;
  logic       fire;
  logic       has_res;
  owrs_pkt_t  pkt;

  assign item_in.kind           = owrs_kind_e'(kind_i);
  assign item_in.presence       = presence_i;
  assign item_in.id_bit         = id_bit_i;
  assign item_in.complement_bit = complement_bit_i;

  // an item is decided once its results have a place to go
  assign fire = item_valid && buf_free;

  owrs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .valid_o    (item_valid),
    .item_o     (item_q),
    .take_i     (fire)
  );

  owrs_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_q),
    .has_res_o (has_res),
    .pkt_o     (pkt)
  );

  owrs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && has_res),
    .pkt_i       (pkt),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .action_o    (action_o),
    .byte_out_o  (byte_out_o),
    .bit_out_o   (bit_out_o),
    .found_o     (found_o),
    .rom_id_o    (rom_id_o),
    .last_o      (last_o)
  );

  // a found id never has a zero family byte
  a_found_family: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_DONE && found_o) |-> (rom_id_o[7:0] != 8'd0))
    else $error("found id with zero family byte");

  // a direction bit is always followed by another result
  a_bit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_WRITE_BIT) |-> !last_o)
    else $error("write bit marked last");

  // the search command byte is always followed by a pair read
  a_byte_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && action_o == ACT_WRITE_BYTE) |=>
    (out_valid_o && action_o == ACT_READ_PAIR))
    else $error("write byte not followed by pair read");

  // a bus reset and a search done close the results of their item
  a_reset_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_BUS_RESET || action_o == ACT_DONE)) |-> last_o)
    else $error("reset or done not marked last");

endmodule

// ===== test/onewire_rom_search_test.sv =====
// testbench of the 1-wire rom search controller with a bus model of several devices
`timescale 1ns / 100ps

module onewire_rom_search_test;
  import owrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 800;

  // where the search stands between items
  typedef enum logic [1:0] {
    PH_IDLE          = 2'd0,
    PH_WAIT_PRESENCE = 2'd1,
    PH_WAIT_PAIR     = 2'd2
  } search_phase_e;

  // one expected bus action
  typedef struct {
    owrs_action_e act;
    logic [7:0]   cmd_byte;
    logic         dir_bit;
    logic         found;
    logic [63:0]  rom;
    logic         last;
  } search_step_t;

  // search state predictor and queue of expected bus actions
  class search_board;
    logic [63:0]   rom_bits;
    logic [6:0]    last_disc;
    logic [3:0]    last_family_disc;
    logic          last_dev_found;
    logic [6:0]    bit_pos;
    logic [6:0]    last_zero_pos;
    search_phase_e stage;
    search_step_t  pending_steps[$];
    int            errors;

    function new();
      rom_bits = '0;
      last_disc = '0;
      last_family_disc = '0;
      last_dev_found = 1'b0;
      bit_pos = 7'd1;
      last_zero_pos = '0;
      stage = PH_IDLE;
      errors = 0;
    endfunction

    function void put(owrs_action_e a, logic [7:0] b, logic d, logic f, logic [63:0] r,
                      logic l);
      search_step_t s;
      s.act = a;
      s.cmd_byte = b;
      s.dir_bit = d;
      s.found = f;
      s.rom = r;
      s.last = l;
      pending_steps.push_back(s);
    endfunction

    function void clear_search();
      last_disc = '0;
      last_family_disc = '0;
      last_dev_found = 1'b0;
    endfunction

    // failed search: done without a device, rom bits kept
    function void fail_search();
      clear_search();
      stage = PH_IDLE;
      put(ACT_DONE, 8'h00, 1'b0, 1'b0, rom_bits, 1'b1);
    endfunction

    // predict the actions caused by one accepted item, return how many
    function int note_request(owrs_item_t it);
      int         before_cnt;
      logic [6:0] prev_pos;
      logic [5:0] idx;
      logic       dir;
      before_cnt = pending_steps.size();
      case (it.kind)
        KIND_START_FIRST, KIND_START_NEXT: begin
          if (it.kind == KIND_START_FIRST) clear_search();
          if (last_dev_found) begin
            fail_search();
          end else begin
            bit_pos = 7'd1;
            last_zero_pos = '0;
            stage = PH_WAIT_PRESENCE;
            put(ACT_BUS_RESET, 8'h00, 1'b0, 1'b0, 64'd0, 1'b1);
          end
        end
        KIND_PRESENCE: begin
          if (stage == PH_WAIT_PRESENCE) begin
            if (!it.presence) begin
              fail_search();
            end else begin
              stage = PH_WAIT_PAIR;
              put(ACT_WRITE_BYTE, SEARCH_CMD, 1'b0, 1'b0, 64'd0, 1'b0);
              put(ACT_READ_PAIR, 8'h00, 1'b0, 1'b0, 64'd0, 1'b1);
            end
          end
        end
        default: begin
          if (stage == PH_WAIT_PAIR) begin
            if (it.id_bit && it.complement_bit) begin
              fail_search();
            end else begin
              prev_pos = bit_pos - 7'd1;
              idx = prev_pos[5:0];
              if (it.id_bit != it.complement_bit) begin
                dir = it.id_bit;
              end else begin
                // discrepancy: follow the previous search
                if (bit_pos < last_disc) dir = rom_bits[idx];
                else dir = (bit_pos == last_disc);
                if (!dir) begin
                  last_zero_pos = bit_pos;
                  if (bit_pos < FAMILY_LIMIT) last_family_disc = bit_pos[3:0];
                end
              end
              rom_bits[idx] = dir;
              bit_pos = bit_pos + 7'd1;
              put(ACT_WRITE_BIT, 8'h00, dir, 1'b0, 64'd0, 1'b0);
              if (bit_pos < END_POSITION) begin
                put(ACT_READ_PAIR, 8'h00, 1'b0, 1'b0, 64'd0, 1'b1);
              end else begin
                last_disc = last_zero_pos;
                if (last_disc == 7'd0) last_dev_found = 1'b1;
                if (rom_bits[7:0] == 8'h00) begin
                  fail_search();
                end else begin
                  stage = PH_IDLE;
                  put(ACT_DONE, 8'h00, 1'b0, 1'b1, rom_bits, 1'b1);
                end
              end
            end
          end
        end
      endcase
      return pending_steps.size() - before_cnt;
    endfunction

    function bit same(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        if (errors < 40)
          $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_action(logic [2:0] act, logic [7:0] b, logic d, logic f,
                               logic [63:0] r, logic l);
      search_step_t want;
      bit           ok;
      if (pending_steps.size() == 0) begin
        if (errors < 40)
          $display("%0t: result with nothing expected, action %0d rom %h", $time, act, r);
        errors++;
        return;
      end
      want = pending_steps.pop_front();
      ok = same("action", 64'(want.act), 64'(act));
      ok &= same("byte_out", 64'(want.cmd_byte), 64'(b));
      ok &= same("bit_out", 64'(want.dir_bit), 64'(d));
      ok &= same("found", 64'(want.found), 64'(f));
      ok &= same("rom_id", want.rom, r);
      ok &= same("last", 64'(want.last), 64'(l));
      if (!ok) errors++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic        presence_i;
  logic        id_bit_i;
  logic        complement_bit_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  action_o;
  logic [7:0]  byte_out_o;
  logic        bit_out_o;
  logic        found_o;
  logic [63:0] rom_id_o;
  logic        last_o;

  search_board board = new();

  int          cycle_count = 0;
  int          active_items = 0;
  int          burst_left = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          rx_cycle = 0;
  int          stall_mode = 0;

  // bus model: up to four devices and which of them still take part
  logic [63:0] device_id[4];
  bit          device_on[4];

  onewire_rom_search dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .presence_i       (presence_i),
    .id_bit_i         (id_bit_i),
    .complement_bit_i (complement_bit_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .byte_out_o       (byte_out_o),
    .bit_out_o        (bit_out_o),
    .found_o          (found_o),
    .rom_id_o         (rom_id_o),
    .last_o           (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_action(action_o, byte_out_o, bit_out_o, found_o, rom_id_o, last_o);
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= rx_cycle[0];
      endcase
    end
  end

  function automatic owrs_item_t make_item(owrs_kind_e k, logic p, logic i, logic c);
    owrs_item_t it;
    it.kind = k;
    it.presence = p;
    it.id_bit = i;
    it.complement_bit = c;
    return it;
  endfunction

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // one input transfer, paced in bursts with gaps
  task automatic push_request(input owrs_item_t it);
    if (burst_left == 0) begin
      idle_input($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    presence_i <= it.presence;
    id_bit_i <= it.id_bit;
    complement_bit_i <= it.complement_bit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (board.note_request(it) > 0) active_items++;
  endtask

  // drop valid first so the last transfer is not offered again
  task automatic wait_drained();
    idle_input(1);
    while (board.pending_steps.size() != 0) @(posedge clk_i);
  endtask

  // full searches over a device population, answering like a wired-and bus
  task automatic bus_round(input int ndev, input bit zero_family);
    logic id_v;
    logic cm_v;
    logic dir;
    for (int d = 0; d < ndev; d++) device_id[d] = {$urandom, $urandom};
    if (zero_family) device_id[0][7:0] = 8'h00;
    for (int s = 0; s < ndev + 2 && active_items < ITEM_TARGET; s++) begin
      push_request(make_item(s == 0 ? KIND_START_FIRST : KIND_START_NEXT,
                             1'($urandom), 1'($urandom), 1'($urandom)));
      if (board.stage != PH_WAIT_PRESENCE) break;
      push_request(make_item(KIND_PRESENCE, $urandom_range(0, 19) != 0, 1'($urandom),
                             1'($urandom)));
      for (int d = 0; d < 4; d++) device_on[d] = (d < ndev);
      for (int k = 0; k < 64 && board.stage == PH_WAIT_PAIR; k++) begin
        id_v = 1'b1;
        cm_v = 1'b1;
        for (int d = 0; d < ndev; d++) begin
          if (device_on[d]) begin
            if (device_id[d][k]) cm_v = 1'b0;
            else id_v = 1'b0;
          end
        end
        // rare bus glitch reads as a 1/1 pair
        if ($urandom_range(0, 299) == 0) begin
          id_v = 1'b1;
          cm_v = 1'b1;
        end
        push_request(make_item(KIND_BIT_PAIR, 1'($urandom), id_v, cm_v));
        dir = board.rom_bits[k];
        for (int d = 0; d < ndev; d++)
          if (device_id[d][k] != dir) device_on[d] = 1'b0;
      end
    end
  endtask

  // search with random pair content, mostly well formed
  task automatic random_search();
    int r;
    push_request(make_item(owrs_kind_e'($urandom_range(0, 1)), 1'($urandom), 1'($urandom),
                           1'($urandom)));
    push_request(make_item(KIND_PRESENCE, 1'b1, 1'($urandom), 1'($urandom)));
    for (int k = 0; k < 64 && board.stage == PH_WAIT_PAIR; k++) begin
      r = $urandom_range(0, 59);
      if (r == 0) push_request(make_item(KIND_BIT_PAIR, 1'($urandom), 1'b1, 1'b1));
      else if (r % 3 == 0) push_request(make_item(KIND_BIT_PAIR, 1'($urandom), 1'b0, 1'b0));
      else if (r % 3 == 1) push_request(make_item(KIND_BIT_PAIR, 1'($urandom), 1'b0, 1'b1));
      else push_request(make_item(KIND_BIT_PAIR, 1'($urandom), 1'b1, 1'b0));
    end
  endtask

  // stimulus
  initial begin
    bit drained_once;
    int pick;
    drained_once = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_START_FIRST;
    presence_i = 1'b0;
    id_bit_i = 1'b0;
    complement_bit_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: answers out of phase, failures, restarts
    push_request(make_item(KIND_PRESENCE, 1'b1, 1'b0, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b1, 1'b0));
    push_request(make_item(KIND_START_FIRST, 1'b0, 1'b0, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b1));
    push_request(make_item(KIND_PRESENCE, 1'b0, 1'b1, 1'b1));
    push_request(make_item(KIND_START_NEXT, 1'b1, 1'b1, 1'b1));
    push_request(make_item(KIND_PRESENCE, 1'b1, 1'b0, 1'b0));
    push_request(make_item(KIND_PRESENCE, 1'b1, 1'b0, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b1));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b1, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b1, 1'b1, 1'b1));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b0));
    push_request(make_item(KIND_START_FIRST, 1'b0, 1'b0, 1'b0));
    push_request(make_item(KIND_PRESENCE, 1'b1, 1'b0, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b0, 1'b0));
    push_request(make_item(KIND_START_NEXT, 1'b0, 1'b0, 1'b0));
    push_request(make_item(KIND_PRESENCE, 1'b1, 1'b0, 1'b0));
    push_request(make_item(KIND_BIT_PAIR, 1'b0, 1'b1, 1'b0));
    push_request(make_item(KIND_START_FIRST, 1'b1, 1'b1, 1'b1));

    // zero family byte on a lone device, then a lone device found and searched past
    bus_round(1, 1'b1);
    bus_round(1, 1'b0);

    // long receiver hold-off while items keep coming
    hold_request = 400;
    bus_round(3, 1'b0);

    while (active_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (!drained_once && active_items > ITEM_TARGET / 2) begin
        // sender pause until everything is out
        drained_once = 1'b1;
        wait_drained();
      end
      if (pick < 5) begin
        bus_round($urandom_range(1, 4), $urandom_range(0, 3) == 0);
      end else if (pick < 7) begin
        random_search();
      end else if (pick < 9) begin
        // broken sequence, dropped by the next start
        push_request(make_item(owrs_kind_e'($urandom_range(0, 1)), 1'($urandom),
                               1'($urandom), 1'($urandom)));
        push_request(make_item(KIND_PRESENCE, $urandom_range(0, 3) != 0, 1'($urandom),
                               1'($urandom)));
        repeat ($urandom_range(0, 10))
          push_request(make_item(KIND_BIT_PAIR, 1'($urandom), 1'($urandom), 1'($urandom)));
      end else begin
        repeat ($urandom_range(1, 6))
          push_request(make_item(owrs_kind_e'($urandom_range(0, 3)), 1'($urandom),
                                 1'($urandom), 1'($urandom)));
      end
    end

    idle_input(1);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/owrs_pkg.sv
rtl/core/owrs_in_reg.sv
rtl/core/owrs_search.sv
rtl/core/owrs_out_buf.sv
rtl/core/onewire_rom_search.sv
test/onewire_rom_search_test.sv
